>>> hw/rtl/binomial_mod_prime_top_macros.svh
// Assertion macros for the binomial mod prime block.
// Used by the port checker; needs clk_i and rst_ni in scope.
`ifndef BINOMIAL_MOD_PRIME_TOP_MACROS_SVH
`define BINOMIAL_MOD_PRIME_TOP_MACROS_SVH

// clocked assertion, off during reset
`define BMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion, checked during reset too
`define BMP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/bmp_pkg.sv
// Shared constants, operation codes and control structs for the binomial mod prime block.
// No dependencies.
`timescale 1ns / 1ps
package bmp_pkg;

  localparam int unsigned TableDepth = 65536;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned IdxW       = AddrW + 1;
  localparam int unsigned PW         = 30;
  localparam int unsigned NW         = 16;
  localparam int unsigned EW         = 17;
  localparam int unsigned SW         = 32;
  localparam int unsigned CntW       = 5;

  localparam logic [PW-1:0] ModulusReset = 30'd1000000007;

  localparam logic [1:0] SelN  = 2'd0;
  localparam logic [1:0] SelK  = 2'd1;
  localparam logic [1:0] SelNk = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SET_ZERO,
    OP_BUILD_INIT,
    OP_MUL_BUILD,
    OP_BUILD_STEP,
    OP_RF_INIT,
    OP_DIV_RF,
    OP_RD,
    OP_MUL_RF,
    OP_RF_NEXT,
    OP_RF_SAVE,
    OP_MUL_DEN,
    OP_EU_INIT,
    OP_DIV_EU,
    OP_EU_NEXT,
    OP_MUL_FINAL,
    OP_SET_RES,
    OP_LOAD_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] rf_sel;
  } cmd_t;

  typedef struct packed {
    logic p_small;
    logic build_more;
    logic n_lt_k;
    logic m_zero;
    logic e_over;
    logic r_zero;
    logic mul_busy;
    logic div_busy;
  } stat_t;

endpackage

>>> hw/rtl/binomial_mod_prime_top.sv
// Top level of the binomial mod prime block: controller plus datapath.
// Depends on bmp_pkg, bmp_ctrl, bmp_datapath.
//
// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------
// request   | in_valid_i / in_ready_o    | n_value_i, k_value_i
// result    | out_valid_o / out_ready_i  | coefficient_o
// modulus   | cfg_we_i (no wait)         | cfg_data_i
//
// One request at a time. The first request after reset or a modulus write first
// fills the factorial memory, one entry at a time over min(p, 65536) entries.
// A request then reduces n, k and n-k one base-p digit at a time and runs the Euclid
// quotient steps (up to about 45) for the inverse; a small modulus gives more digits.
// The 30-step divider and multiplier are each shared across these phases.
// A result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
module binomial_mod_prime_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [bmp_pkg::NW-1:0] n_value_i,
  input  logic [bmp_pkg::NW-1:0] k_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [bmp_pkg::PW-1:0] coefficient_o,
  input  logic                   cfg_we_i,
  input  logic [bmp_pkg::PW-1:0] cfg_data_i
);

  bmp_pkg::cmd_t  cmd;
  bmp_pkg::stat_t stat;

  bmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_we_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bmp_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .n_value_i     (n_value_i),
    .k_value_i     (k_value_i),
    .coefficient_o (coefficient_o)
  );

endmodule

>>> hw/rtl/bmp_datapath.sv
// Datapath: modulus register, factorial memory, serial modular multiplier,
// restoring divider with Bezout update, and operand registers. Uses bmp_pkg.
`timescale 1ns / 1ps
module bmp_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bmp_pkg::cmd_t             cmd_i,
  output bmp_pkg::stat_t            stat_o,
  input  logic                      cfg_we_i,
  input  logic [bmp_pkg::PW-1:0]    cfg_data_i,
  input  logic [bmp_pkg::NW-1:0]    n_value_i,
  input  logic [bmp_pkg::NW-1:0]    k_value_i,
  output logic [bmp_pkg::PW-1:0]    coefficient_o
);

  logic [bmp_pkg::PW-1:0]   p_q;
  logic [bmp_pkg::NW-1:0]   n_q, k_q, m_q;
  logic [bmp_pkg::PW-1:0]   fact_q;
  logic [bmp_pkg::IdxW-1:0] idx_q;
  logic [bmp_pkg::PW-1:0]   acc_q, a1_q, a2_q, res_q, coef_q;
  logic [bmp_pkg::EW-1:0]   e_q, e1_q, esum_q;
  logic [bmp_pkg::PW-1:0]   oldr_q, r_q;
  logic [bmp_pkg::SW-1:0]   olds_q, s_q;

  logic [bmp_pkg::PW-1:0]   mx_q, mb_q, macc_q;
  logic [bmp_pkg::CntW-1:0] mcnt_q;
  logic                     mbusy_q;
  logic                     mul_start;
  logic [bmp_pkg::PW-1:0]   mx_in, mb_in;
  logic [bmp_pkg::PW+1:0]   mt, mp1, mp2;
  logic [bmp_pkg::PW+1:0]   mred;

  logic [bmp_pkg::PW-1:0]   dn_q, dd_q, rem_q, quo_q;
  logic [bmp_pkg::SW-1:0]   u_q, ds_q;
  logic [bmp_pkg::CntW-1:0] dcnt_q;
  logic                     dbusy_q;
  logic [bmp_pkg::PW:0]     dsh, ddif;
  logic                     dge;
  logic [bmp_pkg::PW-1:0]   rem_n;
  logic [bmp_pkg::SW-1:0]   u_n;

  logic [bmp_pkg::PW-1:0]   mem [bmp_pkg::TableDepth];
  logic [bmp_pkg::PW-1:0]   rd_q;
  logic                     rd_oob_q;
  logic                     mem_we;
  logic [bmp_pkg::AddrW-1:0] mem_waddr;
  logic [bmp_pkg::PW-1:0]   mem_wdata;

  logic [bmp_pkg::PW-1:0]   f_val, term;
  logic [bmp_pkg::SW-1:0]   sv, sv_sub;
  logic [bmp_pkg::PW-1:0]   inv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= bmp_pkg::ModulusReset;
    end else if (cfg_we_i) begin
      p_q <= cfg_data_i;
    end
  end

  // table read value, term of the Wilson recursion, inverse from the Bezout coefficient
  always_comb begin
    f_val  = rd_oob_q ? '0 : rd_q;
    term   = (quo_q[0] && (f_val != '0)) ? (p_q - f_val) : f_val;
    sv     = olds_q[bmp_pkg::SW-1] ? (olds_q + bmp_pkg::SW'(p_q)) : olds_q;
    sv_sub = sv - bmp_pkg::SW'(p_q);
    inv    = (sv >= bmp_pkg::SW'(p_q)) ? sv_sub[bmp_pkg::PW-1:0] : sv[bmp_pkg::PW-1:0];
  end

  // multiplier operand select
  always_comb begin
    mul_start = 1'b1;
    mx_in     = '0;
    mb_in     = '0;
    unique case (cmd_i.op)
      bmp_pkg::OP_MUL_BUILD: begin
        mx_in = bmp_pkg::PW'(idx_q);
        mb_in = fact_q;
      end
      bmp_pkg::OP_MUL_RF: begin
        mx_in = acc_q;
        mb_in = term;
      end
      bmp_pkg::OP_MUL_DEN: begin
        mx_in = a2_q;
        mb_in = acc_q;
      end
      bmp_pkg::OP_MUL_FINAL: begin
        mx_in = a1_q;
        mb_in = inv;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // one double-and-add step, reduced below p
  always_comb begin
    mt   = {1'b0, macc_q, 1'b0} + (mx_q[bmp_pkg::PW-1] ? {2'b00, mb_q} : '0);
    mp1  = {2'b00, p_q};
    mp2  = {1'b0, p_q, 1'b0};
    if (mt >= mp2) begin
      mred = mt - mp2;
    end else if (mt >= mp1) begin
      mred = mt - mp1;
    end else begin
      mred = mt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mcnt_q  <= '0;
    end else if (mul_start) begin
      mbusy_q <= 1'b1;
      mcnt_q  <= '0;
    end else if (mbusy_q) begin
      mcnt_q <= mcnt_q + 1'b1;
      if (mcnt_q == bmp_pkg::CntW'(bmp_pkg::PW - 1)) begin
        mbusy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_start) begin
      mx_q   <= mx_in;
      mb_q   <= mb_in;
      macc_q <= '0;
    end else if (mbusy_q) begin
      mx_q   <= {mx_q[bmp_pkg::PW-2:0], 1'b0};
      macc_q <= mred[bmp_pkg::PW-1:0];
    end
  end

  // restoring divide step; u tracks quotient times s modulo 2^SW
  always_comb begin
    dsh   = {rem_q, dn_q[bmp_pkg::PW-1]};
    ddif  = dsh - {1'b0, dd_q};
    dge   = dsh >= {1'b0, dd_q};
    rem_n = dge ? ddif[bmp_pkg::PW-1:0] : dsh[bmp_pkg::PW-1:0];
    u_n   = {u_q[bmp_pkg::SW-2:0], 1'b0} + (dge ? ds_q : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.op == bmp_pkg::OP_DIV_RF || cmd_i.op == bmp_pkg::OP_DIV_EU) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= '0;
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q + 1'b1;
      if (dcnt_q == bmp_pkg::CntW'(bmp_pkg::PW - 1)) begin
        dbusy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == bmp_pkg::OP_DIV_RF) begin
      dn_q  <= bmp_pkg::PW'(m_q);
      dd_q  <= p_q;
      ds_q  <= '0;
      rem_q <= '0;
      quo_q <= '0;
      u_q   <= '0;
    end else if (cmd_i.op == bmp_pkg::OP_DIV_EU) begin
      dn_q  <= oldr_q;
      dd_q  <= r_q;
      ds_q  <= s_q;
      rem_q <= '0;
      quo_q <= '0;
      u_q   <= '0;
    end else if (dbusy_q) begin
      dn_q  <= {dn_q[bmp_pkg::PW-2:0], 1'b0};
      rem_q <= rem_n;
      quo_q <= {quo_q[bmp_pkg::PW-2:0], dge};
      u_q   <= u_n;
    end
  end

  // factorial memory
  always_comb begin
    mem_we    = (cmd_i.op == bmp_pkg::OP_BUILD_INIT) || (cmd_i.op == bmp_pkg::OP_BUILD_STEP);
    mem_waddr = (cmd_i.op == bmp_pkg::OP_BUILD_INIT) ? '0 : idx_q[bmp_pkg::AddrW-1:0];
    mem_wdata = (cmd_i.op == bmp_pkg::OP_BUILD_INIT) ? bmp_pkg::PW'(1) : macc_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.op == bmp_pkg::OP_RD) begin
      rd_q     <= mem[rem_q[bmp_pkg::AddrW-1:0]];
      rd_oob_q <= rem_q >= bmp_pkg::PW'(bmp_pkg::TableDepth);
    end
  end

  // operand and sequencing registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      bmp_pkg::OP_CAPTURE: begin
        n_q <= n_value_i;
        k_q <= k_value_i;
      end
      bmp_pkg::OP_SET_ZERO: begin
        res_q <= '0;
      end
      bmp_pkg::OP_SET_RES: begin
        res_q <= macc_q;
      end
      bmp_pkg::OP_LOAD_OUT: begin
        coef_q <= res_q;
      end
      bmp_pkg::OP_BUILD_INIT: begin
        fact_q <= bmp_pkg::PW'(1);
        idx_q  <= bmp_pkg::IdxW'(1);
      end
      bmp_pkg::OP_BUILD_STEP: begin
        fact_q <= macc_q;
        idx_q  <= idx_q + 1'b1;
      end
      bmp_pkg::OP_RF_INIT: begin
        acc_q <= bmp_pkg::PW'(1);
        e_q   <= '0;
        unique case (cmd_i.rf_sel)
          bmp_pkg::SelN:  m_q <= n_q;
          bmp_pkg::SelK:  m_q <= k_q;
          default:        m_q <= n_q - k_q;
        endcase
      end
      bmp_pkg::OP_MUL_RF: begin
        e_q <= e_q + quo_q[bmp_pkg::EW-1:0];
        m_q <= quo_q[bmp_pkg::NW-1:0];
      end
      bmp_pkg::OP_RF_NEXT: begin
        acc_q <= macc_q;
      end
      bmp_pkg::OP_RF_SAVE: begin
        unique case (cmd_i.rf_sel)
          bmp_pkg::SelN: begin
            a1_q <= acc_q;
            e1_q <= e_q;
          end
          bmp_pkg::SelK: begin
            a2_q   <= acc_q;
            esum_q <= e_q;
          end
          default: begin
            esum_q <= esum_q + e_q;
          end
        endcase
      end
      bmp_pkg::OP_EU_INIT: begin
        oldr_q <= macc_q;
        r_q    <= p_q;
        olds_q <= bmp_pkg::SW'(1);
        s_q    <= '0;
      end
      bmp_pkg::OP_EU_NEXT: begin
        oldr_q <= r_q;
        r_q    <= rem_q;
        olds_q <= s_q;
        s_q    <= olds_q - u_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat_o.p_small    = p_q < bmp_pkg::PW'(2);
    stat_o.build_more = (idx_q < bmp_pkg::IdxW'(bmp_pkg::TableDepth)) &&
                        (bmp_pkg::PW'(idx_q) < p_q);
    stat_o.n_lt_k     = n_q < k_q;
    stat_o.m_zero     = m_q == '0;
    stat_o.e_over     = e1_q > esum_q;
    stat_o.r_zero     = r_q == '0;
    stat_o.mul_busy   = mbusy_q;
    stat_o.div_busy   = dbusy_q;
  end

  assign coefficient_o = coef_q;

endmodule

>>> hw/rtl/bmp_ctrl.sv
// Controller: sequences table build, factorial reductions, Euclid inverse and
// the request handshakes. Drives bmp_datapath through bmp_pkg::cmd_t.
`timescale 1ns / 1ps
module bmp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  logic           cfg_we_i,
  input  bmp_pkg::stat_t stat_i,
  output bmp_pkg::cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_START      = 5'd1;
  localparam logic [4:0] S_BUILD_CHK  = 5'd2;
  localparam logic [4:0] S_BUILD_WAIT = 5'd3;
  localparam logic [4:0] S_QUERY      = 5'd4;
  localparam logic [4:0] S_RF_INIT    = 5'd5;
  localparam logic [4:0] S_RF_CHK     = 5'd6;
  localparam logic [4:0] S_RF_DIV     = 5'd7;
  localparam logic [4:0] S_RF_RD      = 5'd8;
  localparam logic [4:0] S_RF_MUL     = 5'd9;
  localparam logic [4:0] S_RF_END     = 5'd10;
  localparam logic [4:0] S_DEN_WAIT   = 5'd11;
  localparam logic [4:0] S_EU_CHK     = 5'd12;
  localparam logic [4:0] S_EU_DIV     = 5'd13;
  localparam logic [4:0] S_FIN_WAIT   = 5'd14;
  localparam logic [4:0] S_EMIT       = 5'd15;

  logic [4:0] state_q, state_d;
  logic [1:0] sel_q, sel_d;
  logic       ready_q, ready_d;
  logic       ovalid_q, ovalid_d;

  always_comb begin
    state_d       = state_q;
    sel_d         = sel_q;
    ready_d       = ready_q;
    ovalid_d      = ovalid_q && !out_ready_i;
    cmd_o.op      = bmp_pkg::OP_NONE;
    cmd_o.rf_sel  = sel_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = bmp_pkg::OP_CAPTURE;
          state_d  = S_START;
        end
      end
      S_START: begin
        if (stat_i.p_small) begin
          cmd_o.op = bmp_pkg::OP_SET_ZERO;
          state_d  = S_EMIT;
        end else if (!ready_q) begin
          cmd_o.op = bmp_pkg::OP_BUILD_INIT;
          state_d  = S_BUILD_CHK;
        end else begin
          state_d = S_QUERY;
        end
      end
      S_BUILD_CHK: begin
        if (stat_i.build_more) begin
          cmd_o.op = bmp_pkg::OP_MUL_BUILD;
          state_d  = S_BUILD_WAIT;
        end else begin
          ready_d = 1'b1;
          state_d = S_QUERY;
        end
      end
      S_BUILD_WAIT: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = bmp_pkg::OP_BUILD_STEP;
          state_d  = S_BUILD_CHK;
        end
      end
      S_QUERY: begin
        if (stat_i.n_lt_k) begin
          cmd_o.op = bmp_pkg::OP_SET_ZERO;
          state_d  = S_EMIT;
        end else begin
          sel_d   = bmp_pkg::SelN;
          state_d = S_RF_INIT;
        end
      end
      S_RF_INIT: begin
        cmd_o.op = bmp_pkg::OP_RF_INIT;
        state_d  = S_RF_CHK;
      end
      S_RF_CHK: begin
        if (stat_i.m_zero) begin
          cmd_o.op = bmp_pkg::OP_RF_SAVE;
          state_d  = S_RF_END;
        end else begin
          cmd_o.op = bmp_pkg::OP_DIV_RF;
          state_d  = S_RF_DIV;
        end
      end
      S_RF_DIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = bmp_pkg::OP_RD;
          state_d  = S_RF_RD;
        end
      end
      S_RF_RD: begin
        cmd_o.op = bmp_pkg::OP_MUL_RF;
        state_d  = S_RF_MUL;
      end
      S_RF_MUL: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = bmp_pkg::OP_RF_NEXT;
          state_d  = S_RF_CHK;
        end
      end
      S_RF_END: begin
        if (sel_q != bmp_pkg::SelNk) begin
          sel_d   = sel_q + 1'b1;
          state_d = S_RF_INIT;
        end else if (stat_i.e_over) begin
          cmd_o.op = bmp_pkg::OP_SET_ZERO;
          state_d  = S_EMIT;
        end else begin
          cmd_o.op = bmp_pkg::OP_MUL_DEN;
          state_d  = S_DEN_WAIT;
        end
      end
      S_DEN_WAIT: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = bmp_pkg::OP_EU_INIT;
          state_d  = S_EU_CHK;
        end
      end
      S_EU_CHK: begin
        if (stat_i.r_zero) begin
          cmd_o.op = bmp_pkg::OP_MUL_FINAL;
          state_d  = S_FIN_WAIT;
        end else begin
          cmd_o.op = bmp_pkg::OP_DIV_EU;
          state_d  = S_EU_DIV;
        end
      end
      S_EU_DIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = bmp_pkg::OP_EU_NEXT;
          state_d  = S_EU_CHK;
        end
      end
      S_FIN_WAIT: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = bmp_pkg::OP_SET_RES;
          state_d  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.op = bmp_pkg::OP_LOAD_OUT;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // drop the table on a modulus write
    if (cfg_we_i) begin
      ready_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sel_q    <= bmp_pkg::SelN;
      ready_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sel_q    <= sel_d;
      ready_q  <= ready_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = ovalid_q;

endmodule

>>> hw/rtl/bmp_checker.sv
// Port checker for binomial_mod_prime_top, attached by bind.
// Depends on bmp_pkg and binomial_mod_prime_top_macros.svh.
`timescale 1ns / 1ps
`include "binomial_mod_prime_top_macros.svh"
module bmp_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic [bmp_pkg::NW-1:0] n_value_i,
  input logic [bmp_pkg::NW-1:0] k_value_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [bmp_pkg::PW-1:0] coefficient_o,
  input logic                   cfg_we_i,
  input logic [bmp_pkg::PW-1:0] cfg_data_i
);

  `BMP_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped before taken")
  `BMP_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(coefficient_o), "result changed while stalled")
  `BMP_ASSERT(a_one_at_a_time, in_valid_i && in_ready_o |=> !in_ready_o, "request taken while busy")
  `BMP_ASSERT(a_result_after_work, $rose(out_valid_o) |-> $past(!in_ready_o), "result without work")
  `BMP_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result valid in reset")

endmodule

bind binomial_mod_prime_top bmp_checker u_bmp_checker (.*);
